>>> sv/sha_pkg.sv
// sha_pkg: shared constants and types for the sha-256 hash engine
// round constants, initial hash values and the command structs between modules
// no dependencies
package sha_pkg;

  localparam int WORD_W  = 32;
  localparam int NUM_H   = 8;
  localparam int ROUNDS  = 64;
  localparam int BLK_B   = 64;
  localparam int LEN_W   = 64;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [LEN_W-1:0] BLK_BITS = 64'd512;

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WORD_W-1:0] INIT_H [NUM_H] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // commands from the sequencer to the round unit
  typedef struct packed {
    logic init;   // hash words back to initial values
    logic load;   // working variables from hash words
    logic step;   // one compression round
    logic fold;   // add working variables into hash words
  } sha_rnd_cmd_t;

  // commands from the sequencer to the message schedule
  typedef struct packed {
    logic push;   // shift one byte in
    logic shift;  // advance one schedule word
  } sha_sch_cmd_t;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

endpackage

>>> sv/sha_stream_if.sv
// sha_stream_if: valid/ready channels of the sha-256 hash engine
// sha_msg_if carries message beats in, sha_dig_if carries digest words out
// no dependencies
interface sha_msg_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] message_byte;

  modport source (output valid, action, message_byte, input ready);
  modport sink   (input valid, action, message_byte, output ready);
endinterface

interface sha_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> sv/sha_msg_sched.sv
// sha_msg_sched: block buffer and message schedule as one 16-word shift line
// bytes shift in during absorb, schedule words shift through during the rounds
// depends on sha_pkg
module sha_msg_sched (
  input  logic                 clk,
  input  sha_pkg::sha_sch_cmd_t cmd,
  input  logic [7:0]           byte_in,
  output logic [31:0]          w_cur
);
  import sha_pkg::*;

  localparam int BLK_W = BLK_B * 8;

  // word j of the window sits at blk[BLK_W-1-32j -: 32], word 0 is the oldest
  logic [BLK_W-1:0]  blk;
  logic [WORD_W-1:0] w_1, w_9, w_14, s0, s1, w_new;

  function automatic logic [WORD_W-1:0] win(input logic [BLK_W-1:0] b, input int j);
    win = b[BLK_W-1-WORD_W*j -: WORD_W];
  endfunction

  always_comb begin
    w_cur = win(blk, 0);
    w_1   = win(blk, 1);
    w_9   = win(blk, 9);
    w_14  = win(blk, 14);
    s0    = rotr(w_1, 7) ^ rotr(w_1, 18) ^ (w_1 >> 3);
    s1    = rotr(w_14, 17) ^ rotr(w_14, 19) ^ (w_14 >> 10);
    w_new = s1 + w_9 + s0 + w_cur;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[BLK_W-9:0], byte_in};
    end else if (cmd.shift) begin
      blk <= {blk[BLK_W-WORD_W-1:0], w_new};
    end
  end

endmodule

>>> sv/sha_round.sv
// sha_round: hash words, working variables and the shared compression round
// one round per step command, folded into the hash words at the end of a block
// depends on sha_pkg
module sha_round (
  input  logic                       clk,
  input  logic                       rst,
  input  sha_pkg::sha_rnd_cmd_t      cmd,
  input  logic [31:0]                k,
  input  logic [31:0]                w,
  output logic [7:0][31:0]           hash
);
  import sha_pkg::*;

  logic [WORD_W-1:0] hw [NUM_H];
  logic [WORD_W-1:0] v  [NUM_H];
  logic [WORD_W-1:0] big0, big1, choose, major, x1, x2;

  always_comb begin
    big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    x1     = v[7] + big1 + choose + k + w;
    big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    x2     = big0 + major;
    for (int i = 0; i < NUM_H; i++) begin
      hash[i] = hw[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int i = 0; i < NUM_H; i++) hw[i] <= INIT_H[i];
    end else if (cmd.fold) begin
      for (int i = 0; i < NUM_H; i++) hw[i] <= hw[i] + v[i];
    end
    if (cmd.load) begin
      for (int i = 0; i < NUM_H; i++) v[i] <= hw[i];
    end else if (cmd.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + x1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= x1 + x2;
    end
  end

endmodule

>>> sv/sha256_hash_engine_top.sv
// SHA-256 engine fed one byte per beat. The beat that completes a 64-byte
// block is followed by a busy phase of 64 rounds of the single shared round
// unit, then the fold into the hash words. A finish beat pushes the padding
// and length bytes one per cycle through the block buffer (with a second
// padded block and compression when 56 or more bytes are pending), runs the
// final compression and then sends the eight digest words, one per beat,
// word 0 first, last_word set on word 7. The message side is not ready from
// a block's last byte or a finish until that work is done; after the last
// digest word is registered the engine is back at its initial state.
// depends on sha_pkg, sha_stream_if, sha_msg_sched and sha_round
module sha256_hash_engine_top (
  input  logic         clk,
  input  logic         rst,
  sha_msg_if.sink      msg,
  sha_dig_if.source    digest
);
  import sha_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_FOLD, S_OUT} state_t;

  state_t            state;
  logic [5:0]        fill;
  logic [5:0]        rnd;
  logic [LEN_W-1:0]  bit_length;
  logic              padding, pad_first, len_ok;
  logic [2:0]        widx;
  logic              out_valid;
  logic [31:0]       out_word;
  logic [2:0]        out_index;
  logic              out_last;

  sha_rnd_cmd_t      rcmd;
  sha_sch_cmd_t      scmd;
  logic [7:0]        byte_in;
  logic [31:0]       w_cur;
  logic [7:0][31:0]  hash;
  logic              accept, len_byte, full, out_load;

  assign accept   = msg.valid && msg.ready;
  assign msg.ready = (state == S_IDLE);
  assign full     = (fill == 6'd63);
  assign len_byte = len_ok && (fill >= LEN_POS);
  assign out_load = (state == S_OUT) && (!out_valid || digest.ready);

  always_comb begin
    rcmd    = '0;
    scmd    = '0;
    byte_in = msg.message_byte;
    unique case (state)
      S_IDLE: begin
        scmd.push = accept && !msg.action;
        rcmd.load = accept && !msg.action && full;
      end
      S_PAD: begin
        scmd.push = 1'b1;
        rcmd.load = full;
        if (pad_first) byte_in = PAD_BYTE;
        else if (len_byte) byte_in = bit_length[LEN_W-1 -: 8];
        else byte_in = 8'h00;
      end
      S_COMP: begin
        rcmd.step  = 1'b1;
        scmd.shift = 1'b1;
      end
      S_FOLD: rcmd.fold = 1'b1;
      S_OUT:  rcmd.init = out_load && (widx == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      rnd        <= '0;
      bit_length <= '0;
      padding    <= 1'b0;
      pad_first  <= 1'b0;
      len_ok     <= 1'b0;
      widx       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (digest.ready && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && !msg.action) begin
            fill <= fill + 6'd1;
            if (full) begin
              bit_length <= bit_length + BLK_BITS;
              rnd        <= '0;
              state      <= S_COMP;
            end
          end else if (accept) begin
            bit_length <= bit_length + {{(LEN_W-9){1'b0}}, fill, 3'b000};
            len_ok     <= (fill < LEN_POS);
            pad_first  <= 1'b1;
            padding    <= 1'b1;
            state      <= S_PAD;
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          // length bytes leave from the top of the latched count
          if (!pad_first && len_byte) bit_length <= {bit_length[LEN_W-9:0], 8'h00};
          if (full) begin
            rnd   <= '0;
            state <= S_COMP;
          end
        end
        S_COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'(ROUNDS - 1)) state <= S_FOLD;
        end
        S_FOLD: begin
          if (!padding) begin
            state <= S_IDLE;
          end else if (len_ok) begin
            widx  <= '0;
            state <= S_OUT;
          end else begin
            // extra block: zeros then the length
            len_ok <= 1'b1;
            state  <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_word  <= hash[widx];
            out_index <= widx;
            out_last  <= (widx == 3'd7);
            widx      <= widx + 3'd1;
            if (widx == 3'd7) begin
              padding    <= 1'b0;
              len_ok     <= 1'b0;
              bit_length <= '0;
              state      <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest.valid       = out_valid;
  assign digest.digest_word = out_word;
  assign digest.word_index  = out_index;
  assign digest.last_word   = out_last;

  sha_msg_sched u_sched (
    .clk     (clk),
    .cmd     (scmd),
    .byte_in (byte_in),
    .w_cur   (w_cur)
  );

  sha_round u_round (
    .clk  (clk),
    .rst  (rst),
    .cmd  (rcmd),
    .k    (ROUND_K[rnd]),
    .w    (w_cur),
    .hash (hash)
  );

endmodule

>>> sv/sha_checker.sv
// sha_checker: port-level checks on the sha-256 hash engine
// bound to sha256_hash_engine_top; sees only its ports
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_ready,
  input logic        msg_action,
  input logic        dig_valid,
  input logic        dig_ready,
  input logic [31:0] dig_word,
  input logic [2:0]  dig_index,
  input logic        dig_last
);

  // a waiting digest beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(dig_word) && $stable(dig_index))
    else $error("digest beat changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (dig_last == (dig_index == 3'd7)))
    else $error("last_word does not match word 7");

  // words follow one another without a gap
  a_next: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && !dig_last |=>
      dig_valid && (dig_index == $past(dig_index) + 3'd1))
    else $error("digest words out of order");

  // a finish beat that is taken drops the message side's ready
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (msg_valid && msg_ready && msg_action) |=> !msg_ready)
    else $error("message taken during finish");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_last |-> !msg_ready)
    else $error("message side ready mid digest");

endmodule

bind sha256_hash_engine_top sha_checker u_sha_checker (
  .clk        (clk),
  .rst        (rst),
  .msg_valid  (msg.valid),
  .msg_ready  (msg.ready),
  .msg_action (msg.action),
  .dig_valid  (digest.valid),
  .dig_ready  (digest.ready),
  .dig_word   (digest.digest_word),
  .dig_index  (digest.word_index),
  .dig_last   (digest.last_word)
);
